@@ hw/rtl/artnet_dmx_voxel_writer_assert.svh @@
// Assertion macros shared by the voxel writer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ARTNET_DMX_VOXEL_WRITER_ASSERT_SVH
`define ARTNET_DMX_VOXEL_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define AVW_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AVW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/avw_pkg.sv @@
// Shared types, constants and helpers of the Art-Net voxel writer.
// Used by the controller, the datapath, the divider and the top level.
package avw_pkg;

    // Store and packet geometry
    localparam int unsigned STORE_DEPTH         = 65536;
    localparam int unsigned ADDR_W              = $clog2(STORE_DEPTH);
    localparam int unsigned LIMIT_W             = ADDR_W + 1;
    localparam int unsigned MAX_PACKET_BYTES    = 1024;
    localparam int unsigned POS_W               = $clog2(MAX_PACKET_BYTES) + 1;
    localparam int unsigned MAX_DMX_BYTES       = 512;
    localparam int unsigned LEN_W               = $clog2(MAX_DMX_BYTES) + 1;
    localparam int unsigned PIXELS_PER_UNIVERSE = 170;
    localparam int unsigned PIX_W               = 8;
    localparam int unsigned DATA_START          = 18;
    localparam int unsigned K_W = $clog2((MAX_PACKET_BYTES - DATA_START) / 3 + 1);

    // Header byte positions
    localparam int unsigned POS_SIG_END = 8;
    localparam int unsigned POS_OPC_LO  = 8;
    localparam int unsigned POS_OPC_HI  = 9;
    localparam int unsigned POS_UNI_LO  = 14;
    localparam int unsigned POS_UNI_HI  = 15;
    localparam int unsigned POS_LEN_HI  = 16;
    localparam int unsigned POS_LEN_LO  = 17;
    localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;

    // Arithmetic widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DIV_W      = 16;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int unsigned GRID_W     = 9;
    localparam int unsigned WH_W       = 2 * GRID_W;
    localparam int unsigned REMMUL_W   = DIV_W + PIX_W;
    localparam int unsigned LPROD_W    = DIV_W + WH_W;
    localparam int unsigned BASE_W     = LPROD_W + 2;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned M_DATA_W   = ADDR_W + 3 * BYTE_W;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [K_W-1:0]        k_t;
    typedef logic [K_W+1:0]        k3_t;
    typedef logic [PIX_W-1:0]      kp_t;
    typedef logic [DIV_W-1:0]      div_t;
    typedef logic [DIV_CNT_W-1:0]  div_cnt_t;
    typedef logic [BASE_W-1:0]     base_t;
    typedef logic [LIMIT_W-1:0]    limit_t;
    typedef logic [REMMUL_W-1:0]   remmul_t;
    typedef logic [LPROD_W-1:0]    lprod_t;
    typedef logic [WH_W-1:0]       wh_t;
    typedef logic [GRID_W-1:0]     grid_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_UNIV_LAYER  = 3'd2,
        CFG_LAYER_SPAN  = 3'd3,
        CFG_CUBE_BASE   = 3'd4,
        CFG_STORE_SIZE  = 3'd5
    } cfg_index_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A_GO,
        ST_DIV_A_RUN,
        ST_DIV_B_GO,
        ST_DIV_B_RUN,
        ST_MUL_A,
        ST_MUL_B,
        ST_BASE,
        ST_ADDR
    } avw_state_e;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // input item taken this cycle
        logic div_start;   // launch the shared divider
        logic div_second;  // operands: quotient / layer_span
        logic rem_load;    // keep universe remainder
        logic mul_a;       // width*height and remainder*170
        logic mul_b;       // layer * (width*height)
        logic base_load;   // sum into the cached base
        logic out_load;    // write the result register
    } avw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic triple_hit;  // current byte completes a triple of a good header within the DMX length
        logic cache_valid; // base address matches universe and config
        logic div_done;    // divider result ready
        logic addr_ok;     // address below the store limit
        logic out_free;    // result register can take a new item
    } avw_status_t;

    // Expected "Art-Net" signature, zero terminated
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            3'd0: val = 8'h41;
            3'd1: val = 8'h72;
            3'd2: val = 8'h74;
            3'd3: val = 8'h2D;
            3'd4: val = 8'h4E;
            3'd5: val = 8'h65;
            3'd6: val = 8'h74;
            3'd7: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/artnet_dmx_voxel_writer.sv @@
// Art-Net ArtDmx receiver: payload bytes in, one voxel pixel write per in-range RGB triple.
// Throughput: one byte per cycle, except the third byte of an in-length triple, which
// holds the input through the address step if the layer base is cached, and otherwise
// also through two 16-step runs of the shared divider and three multiply/add steps;
// the address step waits while the result register is full. m_tdata is registered.
// Reset: aresetn is synchronous, active low; control registers to defaults, parser idle.
module artnet_dmx_voxel_writer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [avw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [avw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [avw_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [avw_pkg::M_DATA_W-1:0]       m_tdata    // [15:0] pixel_address,
                                                          // [23:16] red, [31:24] green,
                                                          // [39:32] blue
);

    avw_pkg::avw_cmd_t    cmd;
    avw_pkg::avw_status_t status;

    avw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    avw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/avw_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on avw_pkg for the operand width.
module avw_divider (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  avw_pkg::div_t dividend,
    input  avw_pkg::div_t divisor,
    output avw_pkg::div_t quotient,
    output avw_pkg::div_t remainder,
    output logic          done
);

    avw_pkg::div_t     quo_reg, quo_next;
    avw_pkg::div_t     rem_reg, rem_next;
    avw_pkg::div_t     dsr_reg, dsr_next;
    avw_pkg::div_cnt_t cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [avw_pkg::DIV_W:0] shifted;
    logic [avw_pkg::DIV_W:0] trial;
    logic                    fits;

    // One restoring step
    always_comb begin
        shifted = {rem_reg, quo_reg[avw_pkg::DIV_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = avw_pkg::div_cnt_t'(avw_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[avw_pkg::DIV_W-1:0] : shifted[avw_pkg::DIV_W-1:0];
            quo_next = {quo_reg[avw_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - avw_pkg::div_cnt_t'(1);
            if (cnt_reg == avw_pkg::div_cnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ hw/rtl/avw_datapath.sv @@
// Datapath: header parser, configuration registers, address arithmetic
// and the result register. Depends on avw_pkg, avw_divider and the assert header.
`include "artnet_dmx_voxel_writer_assert.svh"

module avw_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [avw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [avw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [avw_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                            s_tlast,
    input  avw_pkg::avw_cmd_t               cmd,
    output avw_pkg::avw_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [avw_pkg::M_DATA_W-1:0]    m_tdata
);

    // Configuration registers
    avw_pkg::grid_t                    width_reg, width_next;
    avw_pkg::grid_t                    height_reg, height_next;
    avw_pkg::div_t                     upl_reg, upl_next;
    avw_pkg::grid_t                    span_reg, span_next;
    logic [avw_pkg::ADDR_W-1:0]        cube_reg, cube_next;
    avw_pkg::limit_t                   size_reg, size_next;

    // Packet parse state
    avw_pkg::pos_t                     pos_reg, pos_next;
    logic                              hdr_good_reg, hdr_good_next;
    logic [avw_pkg::BYTE_W-1:0]        opc_lo_reg, opc_lo_next;
    avw_pkg::div_t                     uni_reg, uni_next;
    logic [avw_pkg::BYTE_W-1:0]        len_hi_reg, len_hi_next;
    avw_pkg::len_t                     len_reg, len_next;
    logic [avw_pkg::BYTE_W-1:0]        first_reg, first_next;
    logic [avw_pkg::BYTE_W-1:0]        second_reg, second_next;
    logic [1:0]                        phase_reg, phase_next;
    avw_pkg::k_t                       k_reg, k_next;

    // Pending triple and address pipeline
    avw_pkg::div_t                     pend_uni_reg, pend_uni_next;
    avw_pkg::kp_t                      pend_k_reg, pend_k_next;
    logic [3*avw_pkg::BYTE_W-1:0]      pend_rgb_reg, pend_rgb_next;
    avw_pkg::div_t                     rem_reg, rem_next;
    avw_pkg::wh_t                      wh_reg, wh_next;
    avw_pkg::remmul_t                  remmul_reg, remmul_next;
    avw_pkg::lprod_t                   lprod_reg, lprod_next;
    avw_pkg::base_t                    base_reg, base_next;
    logic                              cache_valid_reg, cache_valid_next;

    // Result register
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [avw_pkg::M_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // Divider hookup
    avw_pkg::div_t                     div_dividend, div_divisor, div_quot, div_rem;
    logic                              div_done;

    logic                              in_window;
    logic                              data_byte;
    avw_pkg::k3_t                      k3;
    logic [2*avw_pkg::BYTE_W-1:0]      word16;
    avw_pkg::div_t                     upl_eff, span_eff;
    avw_pkg::limit_t                   limit;
    avw_pkg::base_t                    addr_full;
    logic                              triple_hit;

    avw_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Zero divisors behave as one
    always_comb begin
        upl_eff      = (upl_reg == '0) ? avw_pkg::div_t'(1) : upl_reg;
        span_eff     = (span_reg == '0) ? avw_pkg::div_t'(1) : avw_pkg::div_t'(span_reg);
        div_dividend = cmd.div_second ? div_quot : pend_uni_reg;
        div_divisor  = cmd.div_second ? span_eff : upl_eff;
    end

    // Byte classification for the current input item
    always_comb begin
        in_window  = (pos_reg < avw_pkg::pos_t'(avw_pkg::MAX_PACKET_BYTES));
        data_byte  = in_window && (pos_reg >= avw_pkg::pos_t'(avw_pkg::DATA_START));
        k3         = {k_reg, 1'b0} + avw_pkg::k3_t'(k_reg);
        word16     = {len_hi_reg, s_tdata};
        triple_hit = data_byte && hdr_good_reg && (phase_reg == 2'd2)
                     && (k3 < avw_pkg::k3_t'(len_reg));
    end

    // Configuration writes
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        upl_next    = upl_reg;
        span_next   = span_reg;
        cube_next   = cube_reg;
        size_next   = size_reg;
        if (cfg_wr_en) begin
            unique case (avw_pkg::cfg_index_e'(cfg_index))
                avw_pkg::CFG_GRID_WIDTH:  width_next  = cfg_wdata[avw_pkg::GRID_W-1:0];
                avw_pkg::CFG_GRID_HEIGHT: height_next = cfg_wdata[avw_pkg::GRID_W-1:0];
                avw_pkg::CFG_UNIV_LAYER:  upl_next    = cfg_wdata[avw_pkg::DIV_W-1:0];
                avw_pkg::CFG_LAYER_SPAN:  span_next   = cfg_wdata[avw_pkg::GRID_W-1:0];
                avw_pkg::CFG_CUBE_BASE:   cube_next   = cfg_wdata[avw_pkg::ADDR_W-1:0];
                avw_pkg::CFG_STORE_SIZE:  size_next   = cfg_wdata[avw_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Header parse and triple tracking
    always_comb begin
        pos_next      = pos_reg;
        hdr_good_next = hdr_good_reg;
        opc_lo_next   = opc_lo_reg;
        uni_next      = uni_reg;
        len_hi_next   = len_hi_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        if (cmd.accept) begin
            if (in_window) begin
                pos_next = pos_reg + avw_pkg::pos_t'(1);
                if (pos_reg < avw_pkg::pos_t'(avw_pkg::POS_SIG_END)) begin
                    if (s_tdata != avw_pkg::sig_byte(pos_reg[2:0])) hdr_good_next = 1'b0;
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_OPC_LO)) begin
                    opc_lo_next = s_tdata;
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_OPC_HI)) begin
                    if ({s_tdata, opc_lo_reg} != avw_pkg::ARTDMX_OPCODE) hdr_good_next = 1'b0;
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_UNI_LO)) begin
                    uni_next = {8'h00, s_tdata};
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_UNI_HI)) begin
                    uni_next = {s_tdata, uni_reg[avw_pkg::BYTE_W-1:0]};
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_LEN_HI)) begin
                    len_hi_next = s_tdata;
                end else if (pos_reg == avw_pkg::pos_t'(avw_pkg::POS_LEN_LO)) begin
                    // DMX length is big-endian; cap at one full universe
                    len_next = (word16 > 16'(avw_pkg::MAX_DMX_BYTES))
                               ? avw_pkg::len_t'(avw_pkg::MAX_DMX_BYTES)
                               : word16[avw_pkg::LEN_W-1:0];
                end else if (data_byte) begin
                    case (phase_reg)
                        2'd0: begin
                            first_next = s_tdata;
                            phase_next = 2'd1;
                        end
                        2'd1: begin
                            second_next = s_tdata;
                            phase_next  = 2'd2;
                        end
                        default: begin
                            phase_next = 2'd0;
                            k_next     = k_reg + avw_pkg::k_t'(1);
                        end
                    endcase
                end
            end
            // End of datagram returns the parser to its start
            if (s_tlast) begin
                pos_next      = '0;
                hdr_good_next = 1'b1;
                phase_next    = 2'd0;
                k_next        = '0;
            end
        end
    end

    // Address arithmetic, one step per controller command
    always_comb begin
        pend_uni_next    = pend_uni_reg;
        pend_k_next      = pend_k_reg;
        pend_rgb_next    = pend_rgb_reg;
        rem_next         = rem_reg;
        wh_next          = wh_reg;
        remmul_next      = remmul_reg;
        lprod_next       = lprod_reg;
        base_next        = base_reg;
        cache_valid_next = cache_valid_reg;
        if (cmd.accept && triple_hit) begin
            pend_uni_next = uni_reg;
            pend_k_next   = k_reg[avw_pkg::PIX_W-1:0];
            pend_rgb_next = {s_tdata, second_reg, first_reg};
        end
        if (cmd.rem_load) rem_next = div_rem;
        if (cmd.mul_a) begin
            wh_next     = avw_pkg::wh_t'(width_reg * height_reg);
            remmul_next = avw_pkg::remmul_t'(rem_reg * avw_pkg::PIX_W'(avw_pkg::PIXELS_PER_UNIVERSE));
        end
        if (cmd.mul_b) lprod_next = avw_pkg::lprod_t'(div_quot * wh_reg);
        if (cmd.base_load) begin
            base_next = avw_pkg::base_t'(cube_reg) + avw_pkg::base_t'(remmul_reg)
                        + avw_pkg::base_t'(lprod_reg);
            cache_valid_next = 1'b1;
        end
        // A new universe or any register write invalidates the cached base
        if (cfg_wr_en || (cmd.accept && pos_reg == avw_pkg::pos_t'(avw_pkg::POS_UNI_HI)))
            cache_valid_next = 1'b0;
    end

    // Final address and store limit
    always_comb begin
        limit = (size_reg > avw_pkg::limit_t'(avw_pkg::STORE_DEPTH))
                ? avw_pkg::limit_t'(avw_pkg::STORE_DEPTH) : size_reg;
        addr_full = base_reg + avw_pkg::base_t'(pend_k_reg);
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {pend_rgb_reg, addr_full[avw_pkg::ADDR_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        opc_lo_reg   <= opc_lo_next;
        uni_reg      <= uni_next;
        len_hi_reg   <= len_hi_next;
        len_reg      <= len_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        pend_uni_reg <= pend_uni_next;
        pend_k_reg   <= pend_k_next;
        pend_rgb_reg <= pend_rgb_next;
        rem_reg      <= rem_next;
        wh_reg       <= wh_next;
        remmul_reg   <= remmul_next;
        lprod_reg    <= lprod_next;
        base_reg     <= base_next;
        m_tdata_reg  <= m_tdata_next;
        if (!aresetn) begin
            width_reg       <= avw_pkg::grid_t'(20);
            height_reg      <= avw_pkg::grid_t'(20);
            upl_reg         <= avw_pkg::div_t'(3);
            span_reg        <= avw_pkg::grid_t'(1);
            cube_reg        <= '0;
            size_reg        <= avw_pkg::limit_t'(8000);
            pos_reg         <= '0;
            hdr_good_reg    <= 1'b1;
            phase_reg       <= 2'd0;
            k_reg           <= '0;
            cache_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            upl_reg         <= upl_next;
            span_reg        <= span_next;
            cube_reg        <= cube_next;
            size_reg        <= size_next;
            pos_reg         <= pos_next;
            hdr_good_reg    <= hdr_good_next;
            phase_reg       <= phase_next;
            k_reg           <= k_next;
            cache_valid_reg <= cache_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_comb begin
        status.triple_hit  = triple_hit;
        status.cache_valid = cache_valid_reg;
        status.div_done    = div_done;
        status.addr_ok     = (addr_full < avw_pkg::base_t'(limit));
        status.out_free    = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `AVW_ASSERT_IMPLY(a_out_slot_free, aclk, aresetn, cmd.out_load, (!m_tvalid_reg || m_tready), "result overwritten while held")
    `AVW_ASSERT_NEXT(a_last_clears, aclk, aresetn, cmd.accept && s_tlast, (pos_reg == '0) && hdr_good_reg && (k_reg == '0), "parser not cleared after last byte")

endmodule

@@ hw/rtl/avw_ctrl.sv @@
// Controller state machine: input handshake and address sequencing.
// Depends on avw_pkg and the assert header.
`include "artnet_dmx_voxel_writer_assert.svh"

module avw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  avw_pkg::avw_status_t status,
    output avw_pkg::avw_cmd_t    cmd
);

    avw_pkg::avw_state_e state_reg, state_next;
    logic                accept;

    assign accept = s_tvalid && (state_reg == avw_pkg::ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            avw_pkg::ST_IDLE: begin
                if (accept && status.triple_hit)
                    state_next = status.cache_valid ? avw_pkg::ST_ADDR : avw_pkg::ST_DIV_A_GO;
            end
            avw_pkg::ST_DIV_A_GO:  state_next = avw_pkg::ST_DIV_A_RUN;
            avw_pkg::ST_DIV_A_RUN: if (status.div_done) state_next = avw_pkg::ST_DIV_B_GO;
            avw_pkg::ST_DIV_B_GO:  state_next = avw_pkg::ST_DIV_B_RUN;
            avw_pkg::ST_DIV_B_RUN: if (status.div_done) state_next = avw_pkg::ST_MUL_A;
            avw_pkg::ST_MUL_A:     state_next = avw_pkg::ST_MUL_B;
            avw_pkg::ST_MUL_B:     state_next = avw_pkg::ST_BASE;
            avw_pkg::ST_BASE:      state_next = avw_pkg::ST_ADDR;
            avw_pkg::ST_ADDR: begin
                // Out of range drops at once; in range waits for the result slot
                if (!status.addr_ok || status.out_free) state_next = avw_pkg::ST_IDLE;
            end
            default: state_next = avw_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd            = '0;
        cmd.accept     = accept;
        s_tready       = (state_reg == avw_pkg::ST_IDLE);
        unique case (state_reg)
            avw_pkg::ST_IDLE:      ;
            avw_pkg::ST_DIV_A_GO:  cmd.div_start = 1'b1;
            avw_pkg::ST_DIV_A_RUN: cmd.rem_load = status.div_done;
            avw_pkg::ST_DIV_B_GO: begin
                cmd.div_start  = 1'b1;
                cmd.div_second = 1'b1;
            end
            avw_pkg::ST_DIV_B_RUN: cmd.div_second = 1'b1;
            avw_pkg::ST_MUL_A:     cmd.mul_a = 1'b1;
            avw_pkg::ST_MUL_B:     cmd.mul_b = 1'b1;
            avw_pkg::ST_BASE:      cmd.base_load = 1'b1;
            avw_pkg::ST_ADDR:      cmd.out_load = status.addr_ok && status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= avw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Checks
    `AVW_ASSERT_IMPLY(a_addr_has_base, aclk, aresetn, state_reg == avw_pkg::ST_ADDR, status.cache_valid, "address stage without a valid base")
    `AVW_ASSERT_IMPLY(a_idle_div_quiet, aclk, aresetn, state_reg == avw_pkg::ST_IDLE, !status.div_done, "divider finished outside a division step")
    `AVW_ASSERT_NEXT(a_hit_leaves_idle, aclk, aresetn, accept && status.triple_hit, state_reg != avw_pkg::ST_IDLE, "triple accepted but no address step")

endmodule

@@ test/tb_artnet_dmx_voxel_writer.sv @@
// Self-checking testbench for artnet_dmx_voxel_writer: feeds Art-Net datagrams byte by byte
// and compares every pixel write against an in-bench ArtDmx parser model.
// Depends on avw_pkg and the artnet_dmx_voxel_writer RTL only.
module tb_artnet_dmx_voxel_writer;
    import avw_pkg::*;

    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam logic [63:0] ARTNET_ID    = {"Art-Net", 8'h00};

    typedef struct packed {
        logic [15:0] pixel_address;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Parser model: register copy
    logic [8:0]  grid_w, grid_h, span_cfg;
    logic [15:0] upl_cfg, base_cfg;
    logic [16:0] size_cfg;

    // Parser model: per-datagram state
    int unsigned pkt_pos;
    bit          hdr_ok;
    logic [15:0] opcode_seen, universe_seen;
    int unsigned dmx_len;
    logic [7:0]  red_keep, green_keep;

    pixel_write_t pixel_writes[$];
    logic [7:0]   frame_bytes[$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    artnet_dmx_voxel_writer i_dut (.*);

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // ArtDmx parser model
    // ---------------------------------------------------------------
    task automatic clear_packet();
        pkt_pos       = 0;
        hdr_ok        = 1'b1;
        opcode_seen   = '0;
        universe_seen = '0;
        dmx_len       = 0;
        red_keep      = '0;
        green_keep    = '0;
    endtask

    // One accepted byte; queues the pixel write it completes, if any
    task automatic artdmx_parse_byte(input logic [7:0] b, input logic last);
        int unsigned d, k;
        logic [63:0] uni, upl_e, span_e, layer, idx, addr, limit;
        pixel_write_t wr;
        if (pkt_pos < MAX_PACKET_BYTES) begin
            if (pkt_pos < POS_SIG_END) begin
                if (b != ARTNET_ID[63 - 8*pkt_pos -: 8]) hdr_ok = 1'b0;
            end else if (pkt_pos == POS_OPC_LO) begin
                opcode_seen = {8'h00, b};
            end else if (pkt_pos == POS_OPC_HI) begin
                opcode_seen[15:8] = b;
                if (opcode_seen != ARTDMX_OPCODE) hdr_ok = 1'b0;
            end else if (pkt_pos == POS_UNI_LO) begin
                universe_seen = {8'h00, b};
            end else if (pkt_pos == POS_UNI_HI) begin
                universe_seen[15:8] = b;
            end else if (pkt_pos == POS_LEN_HI) begin
                dmx_len = {b, 8'h00};
            end else if (pkt_pos == POS_LEN_LO) begin
                dmx_len = dmx_len | b;
                if (dmx_len > MAX_DMX_BYTES) dmx_len = MAX_DMX_BYTES;
            end else if (pkt_pos >= DATA_START) begin
                d = pkt_pos - DATA_START;
                if (d % 3 == 0) begin
                    red_keep = b;
                end else if (d % 3 == 1) begin
                    green_keep = b;
                end else begin
                    k = d / 3;
                    if (hdr_ok && 3 * k < dmx_len) begin
                        // zero divisors behave as one
                        upl_e  = (upl_cfg == 0) ? 64'd1 : {48'd0, upl_cfg};
                        span_e = (span_cfg == 0) ? 64'd1 : {55'd0, span_cfg};
                        uni    = {48'd0, universe_seen};
                        layer  = (uni / upl_e) / span_e;
                        idx    = (uni % upl_e) * PIXELS_PER_UNIVERSE + k;
                        addr   = {48'd0, base_cfg} + idx
                                 + layer * {55'd0, grid_w} * {55'd0, grid_h};
                        limit  = (size_cfg > STORE_DEPTH) ? STORE_DEPTH : {47'd0, size_cfg};
                        if (addr < limit) begin
                            wr.pixel_address = addr[15:0];
                            wr.red           = red_keep;
                            wr.green         = green_keep;
                            wr.blue          = b;
                            pixel_writes.push_back(wr);
                        end
                    end
                end
            end
            pkt_pos++;
        end
        if (last) clear_packet();
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_writes
        pixel_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_writes.size() == 0) begin
                $display("%0t: unexpected write: expected none, got %0h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pixel_writes.pop_front();
                check_field("pixel_address", want.pixel_address, m_tdata[15:0]);
                check_field("red", {8'h00, want.red}, {8'h00, m_tdata[23:16]});
                check_field("green", {8'h00, want.green}, {8'h00, m_tdata[31:24]});
                check_field("blue", {8'h00, want.blue}, {8'h00, m_tdata[39:32]});
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_request) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        artdmx_parse_byte(value, is_last);
        @(negedge aclk);
    endtask

    // Wait until every pending write has come out and the block has gone quiet
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (pixel_writes.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_e idx, input logic [16:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GRID_WIDTH:  grid_w   = val[8:0];
            CFG_GRID_HEIGHT: grid_h   = val[8:0];
            CFG_UNIV_LAYER:  upl_cfg  = val[15:0];
            CFG_LAYER_SPAN:  span_cfg = val[8:0];
            CFG_CUBE_BASE:   base_cfg = val[15:0];
            CFG_STORE_SIZE:  size_cfg = val[16:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input int w, input int h, input int upl, input int span,
                              input int base, input int size);
        drain_writes();
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_UNIV_LAYER, upl);
        write_reg(CFG_LAYER_SPAN, span);
        write_reg(CFG_CUBE_BASE, base);
        write_reg(CFG_STORE_SIZE, size);
    endtask

    // ArtDmx header into frame_bytes: signature, opcode, 4 filler bytes, universe, length
    task automatic begin_artdmx(input logic [15:0] universe, input logic [15:0] len_field);
        frame_bytes.delete();
        for (int i = 0; i < 8; i++) frame_bytes.push_back(ARTNET_ID[63 - 8*i -: 8]);
        frame_bytes.push_back(ARTDMX_OPCODE[7:0]);
        frame_bytes.push_back(ARTDMX_OPCODE[15:8]);
        repeat (4) frame_bytes.push_back($urandom_range(0, 255));
        frame_bytes.push_back(universe[7:0]);
        frame_bytes.push_back(universe[15:8]);
        frame_bytes.push_back(len_field[15:8]);
        frame_bytes.push_back(len_field[7:0]);
    endtask

    task automatic add_dmx(input int n);
        repeat (n) frame_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic truncate_frame(input int keep);
        while (frame_bytes.size() > keep) frame_bytes.delete(frame_bytes.size() - 1);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic send_dmx_frame(input logic [15:0] universe, input logic [15:0] len_field,
                                  input int n);
        begin_artdmx(universe, len_field);
        add_dmx(n);
        send_frame();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset geometry: layered universe, trailing partial triple
    task automatic test_default_geometry();
        set_idling(0);
        send_dmx_frame(16'd4, 16'd7, 7);
        send_dmx_frame(16'd0, 16'd512, 9);
    endtask

    // Signature and opcode errors, datagrams ending inside the header
    task automatic test_header_checks();
        set_idling(0);
        begin_artdmx(16'd0, 16'd6);
        add_dmx(6);
        frame_bytes[3] = 8'h2E;
        send_frame();
        begin_artdmx(16'd1, 16'd6);
        add_dmx(6);
        frame_bytes[POS_OPC_LO] = ARTDMX_OPCODE[15:8];
        frame_bytes[POS_OPC_HI] = ARTDMX_OPCODE[7:0];
        send_frame();
        begin_artdmx(16'd2, 16'd6);
        truncate_frame(12);
        send_frame();
        begin_artdmx(16'd2, 16'd6);
        truncate_frame(17);
        send_frame();
        send_byte(8'h41, 1'b1);
        send_dmx_frame(16'd2, 16'd6, 6);
    endtask

    // Zero length, data beyond length, length cap and saturation past the size limit
    task automatic test_length_cases();
        set_idling(0);
        send_dmx_frame(16'd0, 16'd0, 12);
        send_dmx_frame(16'd5, 16'd6, 12);
        send_dmx_frame(16'd6, 16'hFFFF, 1100 - DATA_START);
        send_dmx_frame(16'd1, 16'd3, 3);
    endtask

    // Zero divisors and grid, wide grid, top of store, empty store
    task automatic test_config_extremes();
        set_idling(0);
        set_config(0, 0, 0, 0, 0, 65536);
        send_dmx_frame(16'd700, 16'd9, 9);
        set_config(511, 511, 1, 1, 0, 131071);
        send_dmx_frame(16'd0, 16'd9, 9);
        send_dmx_frame(16'd1, 16'd9, 9);
        set_config(256, 256, 65535, 511, 65535, 65536);
        send_dmx_frame(16'd0, 16'd9, 9);
        send_dmx_frame(16'hFFFF, 16'd9, 9);
        send_dmx_frame(16'hFFFE, 16'd9, 9);
        set_config(1, 1, 32768, 256, 0, 0);
        send_dmx_frame(16'd0, 16'd9, 9);
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        set_config(20, 20, 3, 1, 0, 8000);
        set_idling(0);
        hold_request++;
        send_dmx_frame(16'd0, 16'd150, 150);
        send_dmx_frame(16'd5, 16'd150, 150);
    endtask

    // Mostly well-formed datagrams with random content, some broken ones and noise
    task automatic test_random_traffic();
        int sent, pick, len, ndata, span_e, upl_e, j;
        logic [15:0] universe;
        logic [7:0]  flip;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(20, 20, 3, 1, 0, 8000);
                1: set_config(1, 1, 1, 1, 0, 65536);
                2: set_config(256, 256, 32768, 256, 0, 131071);
                default: set_config($urandom_range(1, 256), $urandom_range(1, 256),
                                    $urandom_range(1, 8), $urandom_range(1, 4),
                                    $urandom_range(0, 20000), $urandom_range(20000, 131071));
            endcase
            set_idling(phase % 4);
            upl_e  = (upl_cfg == 0) ? 1 : upl_cfg;
            span_e = (span_cfg == 0) ? 1 : span_cfg;
            sent = 0;
            while (sent < 80) begin
                pick = $urandom_range(0, 99);
                j = $urandom_range(0, 99);
                if (j < 60)
                    universe = $urandom_range(0, 8);
                else if (j < 85)
                    universe = $urandom_range(0, (upl_e * span_e * 3 > 65535) ?
                                                 65535 : upl_e * span_e * 3);
                else
                    universe = $urandom_range(0, 65535);
                j = $urandom_range(0, 99);
                if (j < 70)      len = $urandom_range(0, 60);
                else if (j < 90) len = $urandom_range(0, 600);
                else             len = $urandom_range(0, 65535);
                if ($urandom_range(0, 3) != 0) ndata = (len < 90) ? len : 90;
                else                           ndata = $urandom_range(0, 90);
                begin_artdmx(universe, len);
                add_dmx(ndata);
                if (pick < 75) begin
                    sent += frame_bytes.size();
                end else if (pick < 85) begin
                    // corrupt signature or opcode
                    j = $urandom_range(0, POS_OPC_HI);
                    flip = $urandom_range(1, 255);
                    frame_bytes[j] = frame_bytes[j] ^ flip;
                end else if (pick < 93) begin
                    truncate_frame($urandom_range(1, DATA_START - 1));
                end else begin
                    frame_bytes.delete();
                    add_dmx($urandom_range(1, 30));
                end
                send_frame();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        grid_w    = 9'd20;
        grid_h    = 9'd20;
        upl_cfg   = 16'd3;
        span_cfg  = 9'd1;
        base_cfg  = 16'd0;
        size_cfg  = 17'd8000;
        clear_packet();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_geometry();
        test_header_checks();
        test_length_cases();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        drain_writes();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ artnet_dmx_voxel_writer.f @@
+incdir+hw/rtl
hw/rtl/avw_pkg.sv
hw/rtl/avw_divider.sv
hw/rtl/avw_datapath.sv
hw/rtl/avw_ctrl.sv
hw/rtl/artnet_dmx_voxel_writer.sv
test/tb_artnet_dmx_voxel_writer.sv
